// File: sv/tbmx_pkg.sv
package tbmx_pkg;

	localparam int KEY_BITS   = 20;
	localparam int NODE_COUNT = 2048;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int CNT_W      = $clog2(NODE_COUNT) + 1;
	localparam int LVL_W      = $clog2(KEY_BITS);

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_EV   = 8'b0000_0100,
		S_POP  = 8'b0000_1000,
		S_ALW  = 8'b0001_0000,
		S_CLR  = 8'b0010_0000,
		S_UP   = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		node_t child1;
		node_t child0;
	} link_t;

	typedef struct packed {
		logic  rd_en;
		node_t rd_addr;
		logic  wr_en;
		node_t wr_addr;
		link_t wr_data;
	} link_req_t;

	typedef struct packed {
		logic  pop;
		logic  push;
		node_t push_node;
	} stk_req_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] xor_result;
		status_t             status;
	} res_t;

	function automatic node_t get_child(link_t l, logic b);
		return b ? l.child1 : l.child0;
	endfunction

	function automatic link_t set_child(link_t l, logic b, node_t n);
		link_t r;
		r = l;
		if (b) begin
			r.child1 = n;
		end else begin
			r.child0 = n;
		end
		return r;
	endfunction

endpackage

// File: sv/tbmx_link_mem.sv
module tbmx_link_mem (
	input  logic                clk,
	input  tbmx_pkg::link_req_t req,
	output tbmx_pkg::link_t     rdata
);
	import tbmx_pkg::*;

	link_t mem_q [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata <= mem_q[req.rd_addr];
		end
	end

endmodule

// File: sv/tbmx_free_stack.sv
module tbmx_free_stack (
	input  logic               clk,
	input  logic               arst_n,
	input  tbmx_pkg::stk_req_t req,
	output tbmx_pkg::node_t    fresh,
	output tbmx_pkg::cnt_t     free_count
);
	import tbmx_pkg::*;

	node_t mem_q [NODE_COUNT];
	cnt_t  fc_q;
	cnt_t  lw_q;
	node_t rd_q;
	node_t init_val_q;
	logic  use_init_q;
	cnt_t  top_ix;

	// Entries below the low-water mark have never been pushed and are not read
	// from the memory; their initial contents, the index plus one, are supplied instead.
	assign top_ix     = fc_q - 1'b1;
	assign fresh      = use_init_q ? init_val_q : rd_q;
	assign free_count = fc_q;

	always_ff @(posedge clk) begin
		if (req.push && fc_q < CNT_W'(NODE_COUNT)) begin
			mem_q[fc_q[NODE_W-1:0]] <= req.push_node;
		end
		if (req.pop) begin
			rd_q       <= mem_q[top_ix[NODE_W-1:0]];
			init_val_q <= fc_q[NODE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q       <= CNT_W'(NODE_COUNT - 1);
			lw_q       <= CNT_W'(NODE_COUNT - 1);
			use_init_q <= 1'b0;
		end else if (req.pop) begin
			fc_q       <= top_ix;
			use_init_q <= top_ix < lw_q;
			if (top_ix < lw_q) begin
				lw_q <= top_ix;
			end
		end else if (req.push && fc_q < CNT_W'(NODE_COUNT)) begin
			fc_q <= fc_q + 1'b1;
		end
	end

	a_fc_range: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= CNT_W'(NODE_COUNT - 1)) else $error("free count out of range");
	a_lw_le_fc: assert property (@(posedge clk) disable iff (!arst_n)
		lw_q <= fc_q) else $error("low-water mark above free count");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop |-> fc_q != '0) else $error("pop from empty free list");

endmodule

// File: sv/tbmx_ctrl.sv
module tbmx_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tbmx_pkg::mode_t     in_mode,
	input  logic [19:0]         in_key,
	output logic                res_valid,
	input  logic                res_ready,
	output tbmx_pkg::res_t      res,
	output tbmx_pkg::link_req_t lreq,
	input  tbmx_pkg::link_t     lrdata,
	output tbmx_pkg::stk_req_t  sreq,
	input  tbmx_pkg::node_t     fresh,
	input  tbmx_pkg::cnt_t      free_count
);
	import tbmx_pkg::*;

	state_t              state_q;
	mode_t               mode_q;
	logic [KEY_BITS-1:0] key_q;
	lvl_t                lvl_q;
	node_t               cur_q;
	link_t               cur_links_q;
	logic [KEY_BITS-1:0] acc_q;
	status_t             status_q;
	link_t               root_q;
	node_t               path_q [KEY_BITS];
	link_t               plinks_q [KEY_BITS];

	link_t links;
	logic  kb;
	node_t nx_same;
	node_t nx_opp;
	logic  last_lvl;
	node_t parent;
	link_t up_links;
	cnt_t  need;

	assign links    = (cur_q == '0) ? root_q : lrdata;
	assign kb       = key_q[lvl_q];
	assign nx_same  = get_child(links, kb);
	assign nx_opp   = get_child(links, !kb);
	assign last_lvl = lvl_q == '0;
	assign parent   = path_q[lvl_q];
	assign up_links = set_child(plinks_q[lvl_q], kb, '0);
	assign need     = CNT_W'(lvl_q) + 1'b1;

	assign in_ready       = state_q == S_IDLE;
	assign res_valid      = state_q == S_OUT;
	assign res.xor_result = acc_q;
	assign res.status     = status_q;

	always_comb begin
		lreq         = '0;
		lreq.rd_addr = cur_q;
		sreq         = '0;
		sreq.push_node = cur_q;
		case (state_q)
			S_RD: lreq.rd_en = 1'b1;
			S_POP: sreq.pop = 1'b1;
			S_ALW: begin
				lreq.wr_en   = 1'b1;
				lreq.wr_addr = cur_q;
				lreq.wr_data = set_child(cur_links_q, kb, fresh);
			end
			S_CLR: begin
				lreq.wr_en   = 1'b1;
				lreq.wr_addr = cur_q;
			end
			S_UP: begin
				lreq.wr_en   = 1'b1;
				lreq.wr_addr = parent;
				lreq.wr_data = up_links;
				sreq.push    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EV && mode_q == MODE_REMOVE && nx_same != '0) begin
			path_q[lvl_q]   <= cur_q;
			plinks_q[lvl_q] <= links;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_INSERT;
			key_q       <= '0;
			lvl_q       <= '0;
			cur_q       <= '0;
			cur_links_q <= '0;
			acc_q       <= '0;
			status_q    <= ST_OK;
			root_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					mode_q   <= in_mode;
					key_q    <= in_key;
					lvl_q    <= LVL_W'(KEY_BITS - 1);
					cur_q    <= '0;
					acc_q    <= '0;
					status_q <= ST_OK;
					if (in_mode == MODE_NONE) begin
						state_q <= S_OUT;
					end else if (in_mode == MODE_QUERY && root_q == '0) begin
						status_q <= ST_EMPTY;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					case (mode_q)
						MODE_INSERT: begin
							if (nx_same != '0) begin
								cur_q <= nx_same;
								lvl_q <= lvl_q - 1'b1;
								state_q <= last_lvl ? S_OUT : S_RD;
							end else if (need > free_count) begin
								status_q <= ST_FULL;
								state_q  <= S_OUT;
							end else begin
								cur_links_q <= links;
								state_q     <= S_POP;
							end
						end
						MODE_REMOVE: begin
							if (nx_same == '0) begin
								status_q <= ST_ABSENT;
								state_q  <= S_OUT;
							end else begin
								cur_q <= nx_same;
								if (last_lvl) begin
									state_q <= S_UP;
								end else begin
									lvl_q   <= lvl_q - 1'b1;
									state_q <= S_RD;
								end
							end
						end
						default: begin
							if (nx_opp != '0) begin
								acc_q[lvl_q] <= 1'b1;
								cur_q        <= nx_opp;
								lvl_q        <= lvl_q - 1'b1;
								state_q      <= last_lvl ? S_OUT : S_RD;
							end else if (nx_same != '0) begin
								cur_q   <= nx_same;
								lvl_q   <= lvl_q - 1'b1;
								state_q <= last_lvl ? S_OUT : S_RD;
							end else begin
								state_q <= S_OUT;
							end
						end
					endcase
				end
				S_POP: state_q <= S_ALW;
				S_ALW: begin
					if (cur_q == '0) begin
						root_q <= set_child(cur_links_q, kb, fresh);
					end
					cur_q       <= fresh;
					cur_links_q <= '0;
					if (last_lvl) begin
						state_q <= S_CLR;
					end else begin
						lvl_q   <= lvl_q - 1'b1;
						state_q <= S_POP;
					end
				end
				S_CLR: state_q <= S_OUT;
				S_UP: begin
					// The parent stays when it is the root or still has a child.
					if (parent == '0) begin
						root_q <= up_links;
					end
					cur_q <= parent;
					if (parent == '0 || up_links != '0 || lvl_q == LVL_W'(KEY_BITS - 1)) begin
						state_q <= S_OUT;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				S_OUT: if (res_ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state register not one-hot");
	a_acc_query: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && mode_q != MODE_QUERY) |-> acc_q == '0)
		else $error("nonzero xor result for a non-query transaction");
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		sreq.pop |-> free_count != '0) else $error("allocation with empty pool");

endmodule

// File: sv/binary_trie_max_xor_engine_top.sv
// Binary trie max-XOR engine: each transaction inserts, removes or queries a
// 20-bit key against a trie of 2048 nodes held in a simple dual-port node memory,
// with a free-node stack beside it. One transaction is in flight at a time.
// A walk down the trie takes a memory read state and then a decide state per
// level. An insert that creates new nodes adds a pop state and an allocate
// state per new node and a clear state at the end, and a remove adds an update
// state per freed node on the way back up. The result waits in an output
// register, so the next transaction is accepted while it is held.
module binary_trie_max_xor_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // mode[1:0], key_value[21:2], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // xor_result[19:0], status[21:20], zero pad
);
	import tbmx_pkg::*;

	link_req_t lreq;
	link_t     lrdata;
	stk_req_t  sreq;
	node_t     fresh;
	cnt_t      free_count;
	logic      res_valid;
	logic      res_ready;
	res_t      res;
	res_t      out_q;
	logic      out_valid_q;

	assign res_ready = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {2'b00, out_q.status, out_q.xor_result};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	tbmx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_mode    (mode_t'(s_tdata[1:0])),
		.in_key     (s_tdata[21:2]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.lreq       (lreq),
		.lrdata     (lrdata),
		.sreq       (sreq),
		.fresh      (fresh),
		.free_count (free_count)
	);

	tbmx_link_mem u_link_mem (
		.clk   (clk),
		.req   (lreq),
		.rdata (lrdata)
	);

	tbmx_free_stack u_free_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (sreq),
		.fresh      (fresh),
		.free_count (free_count)
	);

endmodule

// File: tb/sv/tb_binary_trie_max_xor_engine_top.sv
module tb_binary_trie_max_xor_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tbmx_pkg::*;

	localparam int KEY_MASK = (1 << KEY_BITS) - 1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	binary_trie_max_xor_engine_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	typedef struct {
		mode_t               mode;
		logic [KEY_BITS-1:0] key;
		logic                known;
		logic [KEY_BITS-1:0] xor_known;
		status_t             st_known;
	} stim_row_t;

	// Shadow trie.
	int unsigned trie_links[NODE_COUNT][2];
	int unsigned spare_nodes[NODE_COUNT];
	int unsigned spare_count;
	int unsigned path_nodes[KEY_BITS];

	res_t        pending_results[$];
	int          errors;
	int          n_sent;
	int          n_checked;
	int          n_by_status[4];
	int          send_idle_pct;
	int          recv_idle_pct;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic logic trie_bit(logic [KEY_BITS-1:0] k, int lvl);
		return k[lvl];
	endfunction

	function automatic void trie_clear();
		for (int i = 0; i < NODE_COUNT; i++) begin
			trie_links[i][0] = 0;
			trie_links[i][1] = 0;
			spare_nodes[i] = (i + 1 < NODE_COUNT) ? i + 1 : 0;
		end
		spare_count = NODE_COUNT - 1;
	endfunction

	function automatic status_t trie_insert(logic [KEY_BITS-1:0] k);
		int unsigned cur;
		int unsigned nx;
		int unsigned fresh;
		int          lvl;
		cur = 0;
		lvl = KEY_BITS - 1;
		while (lvl >= 0) begin
			nx = trie_links[cur][trie_bit(k, lvl)];
			if (nx == 0) break;
			cur = nx;
			lvl--;
		end
		if (lvl + 1 == 0) return ST_OK;
		if (lvl + 1 > spare_count) return ST_FULL;
		while (lvl >= 0) begin
			spare_count--;
			fresh = spare_nodes[spare_count];
			trie_links[fresh][0] = 0;
			trie_links[fresh][1] = 0;
			trie_links[cur][trie_bit(k, lvl)] = fresh;
			cur = fresh;
			lvl--;
		end
		return ST_OK;
	endfunction

	function automatic status_t trie_remove(logic [KEY_BITS-1:0] k);
		int unsigned cur;
		int unsigned nx;
		int unsigned parent;
		cur = 0;
		for (int d = 0; d < KEY_BITS; d++) begin
			nx = trie_links[cur][trie_bit(k, KEY_BITS - 1 - d)];
			if (nx == 0) return ST_ABSENT;
			path_nodes[d] = cur;
			cur = nx;
		end
		// Free the leaf, then every ancestor left without children.
		for (int d = KEY_BITS - 1; d >= 0; d--) begin
			parent = path_nodes[d];
			if (trie_links[cur][0] != 0 || trie_links[cur][1] != 0) break;
			trie_links[parent][trie_bit(k, KEY_BITS - 1 - d)] = 0;
			if (spare_count < NODE_COUNT) begin
				spare_nodes[spare_count] = cur;
				spare_count++;
			end
			cur = parent;
			if (cur == 0) break;
		end
		return ST_OK;
	endfunction

	function automatic res_t trie_step(mode_t m, logic [KEY_BITS-1:0] k);
		res_t        r;
		int unsigned cur;
		int unsigned nx;
		logic        b;
		r.xor_result = '0;
		r.status = ST_OK;
		case (m)
			MODE_INSERT: r.status = trie_insert(k);
			MODE_REMOVE: r.status = trie_remove(k);
			MODE_QUERY: begin
				if (trie_links[0][0] == 0 && trie_links[0][1] == 0) begin
					r.status = ST_EMPTY;
				end else begin
					cur = 0;
					for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
						b = trie_bit(k, lvl);
						nx = trie_links[cur][!b];
						if (nx != 0) begin
							r.xor_result[lvl] = 1'b1;
						end else begin
							nx = trie_links[cur][b];
							if (nx == 0) break;
						end
						cur = nx;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(mode_t m, logic [KEY_BITS-1:0] k);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, k, m};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(trie_step(m, k));
		n_sent++;
	endtask

	task automatic release_bus();
		s_tvalid <= 1'b0;
	endtask

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.xor_result = m_tdata[19:0];
			got.status = status_t'(m_tdata[21:20]);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result xor=%h status=%0d", $time,
					got.xor_result, got.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_checked++;
				n_by_status[want.status]++;
				if (got.xor_result !== want.xor_result) begin
					$display("%0t: xor_result expected %h actual %h", $time,
						want.xor_result, got.xor_result);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, got.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	stim_row_t directed[] = '{
		'{MODE_QUERY,  20'h00000, 1'b1, 20'h00000, ST_EMPTY},
		'{MODE_REMOVE, 20'h12345, 1'b1, 20'h00000, ST_ABSENT},
		'{MODE_NONE,   20'hFFFFF, 1'b1, 20'h00000, ST_OK},
		'{MODE_INSERT, 20'h00000, 1'b1, 20'h00000, ST_OK},
		'{MODE_QUERY,  20'hFFFFF, 1'b1, 20'hFFFFF, ST_OK},
		'{MODE_QUERY,  20'h00000, 1'b1, 20'h00000, ST_OK},
		'{MODE_INSERT, 20'h00000, 1'b1, 20'h00000, ST_OK},
		'{MODE_INSERT, 20'hFFFFF, 1'b1, 20'h00000, ST_OK},
		'{MODE_QUERY,  20'h00000, 1'b1, 20'hFFFFF, ST_OK},
		'{MODE_QUERY,  20'hA5A5A, 1'b0, 20'h0, ST_OK},
		'{MODE_INSERT, 20'h80000, 1'b0, 20'h0, ST_OK},
		'{MODE_INSERT, 20'h7FFFF, 1'b0, 20'h0, ST_OK},
		'{MODE_QUERY,  20'h7FFFF, 1'b0, 20'h0, ST_OK},
		'{MODE_REMOVE, 20'h80001, 1'b0, 20'h0, ST_OK},
		'{MODE_REMOVE, 20'hFFFFF, 1'b0, 20'h0, ST_OK},
		'{MODE_REMOVE, 20'hFFFFF, 1'b0, 20'h0, ST_OK},
		'{MODE_NONE,   20'h55555, 1'b0, 20'h0, ST_OK},
		'{MODE_REMOVE, 20'h80000, 1'b0, 20'h0, ST_OK},
		'{MODE_REMOVE, 20'h7FFFF, 1'b0, 20'h0, ST_OK},
		'{MODE_REMOVE, 20'h00000, 1'b0, 20'h0, ST_OK},
		'{MODE_QUERY,  20'h3C3C3, 1'b1, 20'h00000, ST_EMPTY}
	};

	function automatic logic [KEY_BITS-1:0] pick_key(logic [KEY_BITS-1:0] pool[$]);
		if (pool.size() > 0 && $urandom_range(99) < 60)
			return pool[$urandom_range(pool.size() - 1)];
		return KEY_BITS'($urandom_range(KEY_MASK));
	endfunction

	initial begin
		logic [KEY_BITS-1:0] stored[$];
		logic [KEY_BITS-1:0] k;
		res_t                r;
		mode_t               m;
		int                  sel;
		int                  phase_len;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_by_status = '{0, 0, 0, 0};
		send_idle_pct = 7;
		recv_idle_pct = 48;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		trie_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].known) begin
				// Ensure the hand-written value agrees with the shadow trie.
				r = trie_step(directed[i].mode, directed[i].key);
				trie_clear();
				foreach (directed[j]) begin
					if (j < i) void'(trie_step(directed[j].mode, directed[j].key));
				end
				if (r.xor_result !== directed[i].xor_known ||
						r.status !== directed[i].st_known) begin
					$display("%0t: table row %0d expected %h/%0d actual %h/%0d", $time, i,
						directed[i].xor_known, directed[i].st_known,
						r.xor_result, r.status);
					errors++;
				end
			end
			send_item(directed[i].mode, directed[i].key);
		end

		// Random part in three idling phases. The traffic keeps a pool of inserted keys
		// that removes and some inserts revisit; one stretch floods the trie with inserts.
		for (int p = 0; p < 3; p++) begin
			if (p == 1) begin
				send_idle_pct = 48;
				recv_idle_pct = 7;
			end else if (p == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			phase_len = (p == 2) ? 240 : 140;
			for (int i = 0; i < phase_len; i++) begin
				sel = $urandom_range(99);
				if (p == 2 && i < 100) begin
					// Flood with spread keys so the node pool runs out.
					m = MODE_INSERT;
					k = KEY_BITS'($urandom_range(KEY_MASK));
				end else if (sel < 40) begin
					m = MODE_INSERT;
					k = ($urandom_range(3) == 0) ? pick_key(stored) :
						($urandom_range(1) ? KEY_BITS'($urandom_range(KEY_MASK)) :
						(stored.size() > 0 ? stored[0] ^ KEY_BITS'($urandom_range(255)) :
						20'h0));
				end else if (sel < 65) begin
					m = MODE_REMOVE;
					k = pick_key(stored);
				end else if (sel < 97) begin
					m = MODE_QUERY;
					k = KEY_BITS'($urandom_range(KEY_MASK));
				end else begin
					m = MODE_NONE;
					k = KEY_BITS'($urandom_range(KEY_MASK));
				end
				if (m == MODE_INSERT) stored.push_back(k);
				send_item(m, k);
			end
			// Drain the trie after the last phase so deletions reach the root.
			if (p == 2) begin
				foreach (stored[j]) send_item(MODE_REMOVE, stored[j]);
				send_item(MODE_QUERY, KEY_BITS'($urandom_range(KEY_MASK)));
			end
		end
		release_bus();

		while (pending_results.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d transactions, checked %0d results.", n_sent, n_checked);
		$display("Status counts: ok %0d, empty %0d, absent %0d, full %0d.",
			n_by_status[0], n_by_status[1], n_by_status[2], n_by_status[3]);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
